// ===== src/fwc_pkg.sv =====
// ----------------------------------------------------------------------------
// FIFO write-back cache package
// Sizes, payload types and control structures shared by the cache row and
// the top level.
// ----------------------------------------------------------------------------
package fwc_pkg;

    localparam int CAPACITY     = 1024;
    localparam int ADDRESS_BITS = 48;
    localparam int FIELD_W      = 48;
    localparam int TAG_W        = (ADDRESS_BITS < FIELD_W) ? ADDRESS_BITS : FIELD_W;
    localparam int CFG_W        = 11;
    localparam int OCC_W        = $clog2(CAPACITY + 1);
    localparam int CMP_W        = (OCC_W > CFG_W) ? OCC_W : CFG_W;
    localparam int CNT_W        = 32;
    localparam int GROUP        = 32;
    localparam int NUM_GROUPS   = (CAPACITY + GROUP - 1) / GROUP;
    localparam int PADDED       = NUM_GROUPS * GROUP;

    localparam logic [CFG_W-1:0] CFG_RESET = CFG_W'(1024);
    localparam logic             ACT_WRITE = 1'b1;

    typedef struct packed {
        logic               action;
        logic [FIELD_W-1:0] block_address;
    } fwc_in_t;

    typedef struct packed {
        logic               hit;
        logic               evicted;
        logic               evicted_dirty;
        logic [FIELD_W-1:0] evicted_address;
        logic [CNT_W-1:0]   hit_total;
        logic [CNT_W-1:0]   miss_total;
        logic [CNT_W-1:0]   writeback_total;
        logic [CNT_W-1:0]   evict_total;
    } fwc_out_t;

    typedef struct packed {
        logic             dirty;
        logic [TAG_W-1:0] tag;
    } fwc_entry_t;

    typedef struct packed {
        logic cmp_en;
        logic grp_en;
        logic shift_en;
        logic mark_dirty;
    } fwc_ctl_t;

    typedef struct packed {
        logic       hit;
        fwc_entry_t oldest;
    } fwc_stat_t;

    function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
        sat_inc = (v == {CNT_W{1'b1}}) ? v : v + CNT_W'(1);
    endfunction

endpackage

// ===== src/fifo_writeback_cache_sim.sv =====
// ----------------------------------------------------------------------------
// FIFO write-back cache
// Fully associative block cache with first-in first-out replacement, dirty
// marks and saturating hit, miss, writeback and eviction counters.
// ----------------------------------------------------------------------------
// Start is taken only while idle; the tag compare in the cell row, the
// registered two-level reduction of the match flags and the update then
// follow, the result is strobed on done, and another request can be taken.
// Reset clears the counters and occupancy and sets the capacity to 1024;
// no clearing pass is needed. Results cannot be stalled by the receiver.
// ----------------------------------------------------------------------------
module fifo_writeback_cache_sim
    import fwc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    output logic             busy,
    input  fwc_in_t          req,
    input  logic             cfg_we,
    input  logic [CFG_W-1:0] cfg_data,
    output logic             done,
    output fwc_out_t         result
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_CMP  = 2'd1;
    localparam logic [1:0] ST_GRP  = 2'd2;
    localparam logic [1:0] ST_UPD  = 2'd3;

    logic [1:0]       state_reg;
    logic [1:0]       state_next;
    logic [CFG_W-1:0] cap_reg;
    logic [CFG_W-1:0] cap_next;
    logic [OCC_W-1:0] occ_reg;
    logic [OCC_W-1:0] occ_next;
    logic [CNT_W-1:0] hit_cnt_reg;
    logic [CNT_W-1:0] hit_cnt_next;
    logic [CNT_W-1:0] miss_cnt_reg;
    logic [CNT_W-1:0] miss_cnt_next;
    logic [CNT_W-1:0] wb_cnt_reg;
    logic [CNT_W-1:0] wb_cnt_next;
    logic [CNT_W-1:0] ev_cnt_reg;
    logic [CNT_W-1:0] ev_cnt_next;
    logic             done_reg;
    logic             done_next;
    fwc_in_t          req_reg;
    fwc_in_t          req_next;
    fwc_out_t         result_reg;
    fwc_out_t         result_next;

    logic             accept;
    logic             upd;
    logic             evict;
    logic [CMP_W-1:0] cap_ext;
    logic [CMP_W-1:0] eff_cap;
    fwc_ctl_t         ctl;
    fwc_stat_t        status;
    logic [TAG_W-1:0] req_tag;

    assign accept  = start && (state_reg == ST_IDLE);
    assign busy    = (state_reg != ST_IDLE);
    assign upd     = (state_reg == ST_UPD);
    assign req_tag = req_reg.block_address[TAG_W-1:0];

    assign cap_ext = CMP_W'(cap_reg);

    always_comb
    begin
        if (cap_ext == '0)
        begin
            eff_cap = CMP_W'(1);
        end
        else if (cap_ext > CMP_W'(CAPACITY))
        begin
            eff_cap = CMP_W'(CAPACITY);
        end
        else
        begin
            eff_cap = cap_ext;
        end
    end

    assign evict = !status.hit && (CMP_W'(occ_reg) >= eff_cap) && (occ_reg != '0);

    always_comb
    begin
        ctl.cmp_en     = (state_reg == ST_CMP);
        ctl.grp_en     = (state_reg == ST_GRP);
        ctl.shift_en   = upd && !status.hit;
        ctl.mark_dirty = upd && status.hit && (req_reg.action == ACT_WRITE);
    end

    fwc_chain u_chain (
        .clk       (clk),
        .rst_n     (rst_n),
        .ctl       (ctl),
        .req_tag   (req_tag),
        .req_write (req_reg.action == ACT_WRITE),
        .occupancy (occ_reg),
        .status    (status)
    );

    always_comb
    begin
        case (state_reg)
            ST_IDLE: state_next = accept ? ST_CMP : ST_IDLE;
            ST_CMP:  state_next = ST_GRP;
            ST_GRP:  state_next = ST_UPD;
            ST_UPD:  state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_comb
    begin
        cap_next      = cfg_we ? cfg_data : cap_reg;
        req_next      = accept ? req : req_reg;
        occ_next      = occ_reg;
        hit_cnt_next  = hit_cnt_reg;
        miss_cnt_next = miss_cnt_reg;
        wb_cnt_next   = wb_cnt_reg;
        ev_cnt_next   = ev_cnt_reg;
        done_next     = upd;
        result_next   = result_reg;
        if (upd)
        begin
            if (status.hit)
            begin
                hit_cnt_next = sat_inc(hit_cnt_reg);
            end
            else
            begin
                miss_cnt_next = sat_inc(miss_cnt_reg);
                if (evict)
                begin
                    ev_cnt_next = sat_inc(ev_cnt_reg);
                    if (status.oldest.dirty)
                    begin
                        wb_cnt_next = sat_inc(wb_cnt_reg);
                    end
                end
                else
                begin
                    occ_next = occ_reg + OCC_W'(1);
                end
            end
            result_next.hit             = status.hit;
            result_next.evicted         = evict;
            result_next.evicted_dirty   = evict && status.oldest.dirty;
            result_next.evicted_address = evict ? FIELD_W'(status.oldest.tag) : '0;
            result_next.hit_total       = hit_cnt_next;
            result_next.miss_total      = miss_cnt_next;
            result_next.writeback_total = wb_cnt_next;
            result_next.evict_total     = ev_cnt_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_IDLE;
            cap_reg      <= CFG_RESET;
            occ_reg      <= '0;
            hit_cnt_reg  <= '0;
            miss_cnt_reg <= '0;
            wb_cnt_reg   <= '0;
            ev_cnt_reg   <= '0;
            done_reg     <= 1'b0;
        end
        else
        begin
            state_reg    <= state_next;
            cap_reg      <= cap_next;
            occ_reg      <= occ_next;
            hit_cnt_reg  <= hit_cnt_next;
            miss_cnt_reg <= miss_cnt_next;
            wb_cnt_reg   <= wb_cnt_next;
            ev_cnt_reg   <= ev_cnt_next;
            done_reg     <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        req_reg    <= req_next;
        result_reg <= result_next;
    end

    assign done   = done_reg;
    assign result = result_reg;

    a_done_after_update: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> ($past(state_reg) == ST_UPD))
        else $error("result strobe without an update cycle");

    a_evict_only_on_miss: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !(result.hit && result.evicted))
        else $error("eviction reported on a hit");

    a_occupancy_bound: assert property (@(posedge clk) disable iff (!rst_n)
        CMP_W'(occ_reg) <= CMP_W'(CAPACITY))
        else $error("occupancy beyond the number of cells");

    a_busy_after_start: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("request taken but block not busy");

endmodule

// ===== src/fwc_cell.sv =====
// ----------------------------------------------------------------------------
// Cache cell
// One entry of the cache row: holds a tag and its dirty mark, compares the
// tag against the request and takes its younger neighbour's entry on a miss.
// ----------------------------------------------------------------------------
module fwc_cell
    import fwc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  fwc_ctl_t         ctl,
    input  logic [TAG_W-1:0] req_tag,
    input  logic             valid,
    input  logic             older_valid,
    input  fwc_entry_t       shift_in,
    output fwc_entry_t       entry,
    output logic             match,
    output logic             oldest
);

    fwc_entry_t entry_reg;
    fwc_entry_t entry_next;
    logic       match_reg;
    logic       match_next;
    logic       oldest_reg;
    logic       oldest_next;

    always_comb
    begin
        entry_next = entry_reg;
        if (ctl.shift_en)
        begin
            entry_next = shift_in;
        end
        else if (ctl.mark_dirty && match_reg)
        begin
            entry_next.dirty = 1'b1;
        end
    end

    always_comb
    begin
        match_next  = match_reg;
        oldest_next = oldest_reg;
        if (ctl.cmp_en)
        begin
            match_next  = valid && (entry_reg.tag == req_tag);
            oldest_next = valid && !older_valid;
        end
    end

    always_ff @(posedge clk)
    begin
        entry_reg <= entry_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            match_reg  <= 1'b0;
            oldest_reg <= 1'b0;
        end
        else
        begin
            match_reg  <= match_next;
            oldest_reg <= oldest_next;
        end
    end

    assign entry  = entry_reg;
    assign match  = match_reg;
    assign oldest = oldest_reg;

endmodule

// ===== src/fwc_chain.sv =====
// ----------------------------------------------------------------------------
// Cache row
// The row of cells, newest at the head, with a registered per-group
// reduction of the hit flags and of the oldest entry.
// ----------------------------------------------------------------------------
module fwc_chain
    import fwc_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  fwc_ctl_t         ctl,
    input  logic [TAG_W-1:0] req_tag,
    input  logic             req_write,
    input  logic [OCC_W-1:0] occupancy,
    output fwc_stat_t        status
);

    fwc_entry_t link   [0:CAPACITY-1];
    fwc_entry_t ent    [0:CAPACITY-1];
    logic       vld    [0:CAPACITY-1];
    logic       match  [0:PADDED-1];
    fwc_entry_t cand   [0:PADDED-1];

    logic       grp_hit_reg  [0:NUM_GROUPS-1];
    logic       grp_hit_next [0:NUM_GROUPS-1];
    fwc_entry_t grp_ev_reg   [0:NUM_GROUPS-1];
    fwc_entry_t grp_ev_next  [0:NUM_GROUPS-1];

    assign link[0] = '{dirty: req_write, tag: req_tag};

    for (genvar i = 0; i < PADDED; i++)
    begin : g_cell
        if (i < CAPACITY)
        begin : g_real
            logic older;
            logic is_oldest;

            assign vld[i] = (occupancy > OCC_W'(i));

            if (i + 1 < CAPACITY)
            begin : g_link
                assign older     = vld[i+1];
                assign link[i+1] = ent[i];
            end
            else
            begin : g_tail
                assign older = 1'b0;
            end

            fwc_cell u_cell (
                .clk         (clk),
                .rst_n       (rst_n),
                .ctl         (ctl),
                .req_tag     (req_tag),
                .valid       (vld[i]),
                .older_valid (older),
                .shift_in    (link[i]),
                .entry       (ent[i]),
                .match       (match[i]),
                .oldest      (is_oldest)
            );

            assign cand[i] = is_oldest ? ent[i] : '0;
        end
        else
        begin : g_pad
            assign match[i] = 1'b0;
            assign cand[i]  = '0;
        end
    end

    always_comb
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            grp_hit_next[g] = grp_hit_reg[g];
            grp_ev_next[g]  = grp_ev_reg[g];
            if (ctl.grp_en)
            begin
                grp_hit_next[g] = 1'b0;
                grp_ev_next[g]  = '0;
                for (int j = 0; j < GROUP; j++)
                begin
                    grp_hit_next[g] = grp_hit_next[g] | match[g*GROUP + j];
                    grp_ev_next[g]  = grp_ev_next[g] | cand[g*GROUP + j];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int g = 0; g < NUM_GROUPS; g++)
            begin
                grp_hit_reg[g] <= 1'b0;
            end
        end
        else
        begin
            for (int g = 0; g < NUM_GROUPS; g++)
            begin
                grp_hit_reg[g] <= grp_hit_next[g];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            grp_ev_reg[g] <= grp_ev_next[g];
        end
    end

    always_comb
    begin
        status = '0;
        for (int g = 0; g < NUM_GROUPS; g++)
        begin
            status.hit    = status.hit | grp_hit_reg[g];
            status.oldest = status.oldest | grp_ev_reg[g];
        end
    end

endmodule
